// ===== src/dmth_pkg.sv =====
// ============================================================================
// dmth_pkg: shared definitions for the traceback hash unit
// Field widths, codes, constants and the controller/datapath handshake types.
// ============================================================================
`default_nettype none

package dmth_pkg;

    localparam int ROW_W     = 5;
    localparam int COL_W     = 5;
    localparam int SCORE_W   = 32;
    localparam int HASH_W    = 32;
    localparam int CFG_W     = 6;
    localparam int CFG_IDX_W = 1;

    localparam int DEF_MAX_ROWS = 32;
    localparam int DEF_MAX_COLS = 32;

    localparam logic [HASH_W-1:0]         HASH_SEED = 32'd5381;
    localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;
    localparam logic [CFG_W-1:0]          CFG_SIZE_RST = 6'd32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 1'b1;

    // Input commands.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_RUN  = 1'b1;

    // Cell selector: the current cell or one of its three neighbors.
    typedef logic [1:0] nb_t;
    localparam nb_t NB_CUR  = 2'd0;
    localparam nb_t NB_DIAG = 2'd1;
    localparam nb_t NB_UP   = 2'd2;
    localparam nb_t NB_LEFT = 2'd3;

    typedef struct packed {
        logic init;
        logic load_wr;
        logic rd_en;
        nb_t  rd_sel;
        logic cap_cur;
        logic best_clr;
        logic cmp_en;
        nb_t  cmp_sel;
        logic emit;
    } dmth_cmd_t;

    typedef struct packed {
        logic size_ok;
        logic out_free;
        logic moved;
    } dmth_sts_t;

    typedef struct packed {
        logic [ROW_W-1:0]          path_row;
        logic [COL_W-1:0]          path_col;
        logic signed [SCORE_W-1:0] path_score;
        logic [HASH_W-1:0]         running_hash;
        logic                      last;
    } dmth_result_t;

endpackage

`default_nettype wire

// ===== src/dmth_ifs.sv =====
// ============================================================================
// dmth channel interfaces
// Valid/ready channels for command items and for path results.
// ============================================================================
`default_nettype none

interface dmth_in_if import dmth_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      command;
    logic [ROW_W-1:0]          row;
    logic [COL_W-1:0]          col;
    logic signed [SCORE_W-1:0] cell_score;

    modport source (output valid, command, row, col, cell_score, input ready);
    modport sink   (input valid, command, row, col, cell_score, output ready);
endinterface

interface dmth_out_if import dmth_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [ROW_W-1:0]          path_row;
    logic [COL_W-1:0]          path_col;
    logic signed [SCORE_W-1:0] path_score;
    logic [HASH_W-1:0]         running_hash;
    logic                      last;

    modport source (output valid, path_row, path_col, path_score, running_hash, last,
                    input ready);
    modport sink   (input valid, path_row, path_col, path_score, running_hash, last,
                    output ready);
endinterface

`default_nettype wire

// ===== src/dmth_ctrl.sv =====
// ============================================================================
// dmth_ctrl: traceback sequencer
// Steps the datapath through current-cell fetch, three neighbor reads and
// the emission of one path cell at a time.
// ============================================================================
`default_nettype none

module dmth_ctrl
    import dmth_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    input  wire logic      in_command,
    output logic           in_ready,
    input  wire dmth_sts_t sts,
    output dmth_cmd_t      cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_CUR_RD   = 3'd1;
    localparam logic [2:0] S_CUR_CAP  = 3'd2;
    localparam logic [2:0] S_DIAG_RD  = 3'd3;
    localparam logic [2:0] S_UP_RD    = 3'd4;
    localparam logic [2:0] S_LEFT_RD  = 3'd5;
    localparam logic [2:0] S_LEFT_CMP = 3'd6;
    localparam logic [2:0] S_EMIT     = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (in_command == CMD_LOAD)
                    begin
                        cmd.load_wr = 1'b1;
                    end
                    else if (sts.size_ok)
                    begin
                        cmd.init   = 1'b1;
                        state_next = S_CUR_RD;
                    end
                end
            end
            S_CUR_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = NB_CUR;
                state_next = S_CUR_CAP;
            end
            S_CUR_CAP:
            begin
                cmd.cap_cur = 1'b1;
                state_next  = S_DIAG_RD;
            end
            S_DIAG_RD:
            begin
                cmd.best_clr = 1'b1;
                cmd.rd_en    = 1'b1;
                cmd.rd_sel   = NB_DIAG;
                state_next   = S_UP_RD;
            end
            S_UP_RD:
            begin
                cmd.cmp_en  = 1'b1;
                cmd.cmp_sel = NB_DIAG;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = NB_UP;
                state_next  = S_LEFT_RD;
            end
            S_LEFT_RD:
            begin
                cmd.cmp_en  = 1'b1;
                cmd.cmp_sel = NB_UP;
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = NB_LEFT;
                state_next  = S_LEFT_CMP;
            end
            S_LEFT_CMP:
            begin
                cmd.cmp_en  = 1'b1;
                cmd.cmp_sel = NB_LEFT;
                state_next  = S_EMIT;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = sts.moved ? S_DIAG_RD : S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // No memory read may be issued while new items are being taken.
    a_no_read_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && cmd.rd_en))
        else $error("memory read issued while accepting items");

    // A result is only produced when the output register can take it.
    a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> sts.out_free)
        else $error("result emitted over a pending result");

    // The final cell of a walk hands control back to the input side.
    a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && !sts.moved) |=> in_ready)
        else $error("walk did not end after its final cell");

endmodule

`default_nettype wire

// ===== src/dmth_dp.sv =====
// ============================================================================
// dmth_dp: traceback datapath
// Score memory, walk position, neighbor maximum search, hash and result
// register.
// ============================================================================
`default_nettype none

module dmth_dp
    import dmth_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [CFG_W-1:0]          cfg_data,
    input  wire logic [ROW_W-1:0]          load_row,
    input  wire logic [COL_W-1:0]          load_col,
    input  wire logic signed [SCORE_W-1:0] load_score,
    input  wire dmth_cmd_t                 cmd,
    output dmth_sts_t                      sts,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output dmth_result_t                   result
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [CFG_W-1:0] ROWS_CAP = CFG_W'(MAX_ROWS);
    localparam logic [CFG_W-1:0] COLS_CAP = CFG_W'(MAX_COLS);

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
        return ADDR_W'(int'(r) * MAX_COLS + int'(c));
    endfunction

    logic [SCORE_W-1:0]        mem [DEPTH];
    logic signed [SCORE_W-1:0] rd_data_reg;

    logic [CFG_W-1:0]          rows_reg;
    logic [CFG_W-1:0]          cols_reg;
    logic [ROW_W-1:0]          r_reg;
    logic [COL_W-1:0]          c_reg;
    logic [HASH_W-1:0]         h_reg;
    logic signed [SCORE_W-1:0] cur_reg;
    logic signed [SCORE_W-1:0] best_reg;
    nb_t                       dir_reg;
    logic                      out_valid_reg;
    dmth_result_t              result_reg;

    logic [CFG_W-1:0]  rows_eff;
    logic [CFG_W-1:0]  cols_eff;
    logic              has_up;
    logic              has_left;
    logic              load_ok;
    logic [ROW_W-1:0]  rd_row;
    logic [COL_W-1:0]  rd_col;
    logic              cand_ok;
    logic              take;
    logic [ROW_W-1:0]  nxt_row;
    logic [COL_W-1:0]  nxt_col;
    logic [HASH_W-1:0] h_new;

    assign rows_eff = (rows_reg > ROWS_CAP) ? ROWS_CAP : rows_reg;
    assign cols_eff = (cols_reg > COLS_CAP) ? COLS_CAP : cols_reg;
    assign has_up   = (r_reg != '0);
    assign has_left = (c_reg != '0);
    assign load_ok  = ({1'b0, load_row} < ROWS_CAP) && ({1'b0, load_col} < COLS_CAP);

    // Neighbor coordinates; a missing neighbor falls back to the current cell
    // so the address always stays inside the memory.
    always_comb
    begin
        rd_row = r_reg;
        rd_col = c_reg;
        unique case (cmd.rd_sel)
            NB_CUR:
            begin
                rd_row = r_reg;
                rd_col = c_reg;
            end
            NB_DIAG:
            begin
                if (has_up && has_left)
                begin
                    rd_row = r_reg - 1'b1;
                    rd_col = c_reg - 1'b1;
                end
            end
            NB_UP:
            begin
                if (has_up)
                begin
                    rd_row = r_reg - 1'b1;
                end
            end
            NB_LEFT:
            begin
                if (has_left)
                begin
                    rd_col = c_reg - 1'b1;
                end
            end
        endcase
    end

    always_comb
    begin
        unique case (cmd.cmp_sel)
            NB_CUR:  cand_ok = 1'b0;
            NB_DIAG: cand_ok = has_up && has_left;
            NB_UP:   cand_ok = has_up;
            NB_LEFT: cand_ok = has_left;
        endcase
    end

    assign take = cmd.cmp_en && cand_ok && (rd_data_reg > best_reg);

    always_comb
    begin
        unique case (dir_reg)
            NB_CUR:
            begin
                nxt_row = r_reg;
                nxt_col = c_reg;
            end
            NB_DIAG:
            begin
                nxt_row = r_reg - 1'b1;
                nxt_col = c_reg - 1'b1;
            end
            NB_UP:
            begin
                nxt_row = r_reg - 1'b1;
                nxt_col = c_reg;
            end
            NB_LEFT:
            begin
                nxt_row = r_reg;
                nxt_col = c_reg - 1'b1;
            end
        endcase
    end

    // hash * 33 is a shift and one add.
    assign h_new = ({h_reg[HASH_W-6:0], 5'b0} + h_reg) ^ cur_reg;

    assign sts.size_ok  = (rows_eff != '0) && (cols_eff != '0);
    assign sts.out_free = !out_valid_reg || out_ready;
    assign sts.moved    = (dir_reg != NB_CUR);

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // Score memory: one write port for loads, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && load_ok)
        begin
            mem[cell_addr(load_row, load_col)] <= load_score;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[cell_addr(rd_row, rd_col)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= CFG_SIZE_RST;
            cols_reg      <= CFG_SIZE_RST;
            r_reg         <= '0;
            c_reg         <= '0;
            h_reg         <= HASH_SEED;
            dir_reg       <= NB_CUR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_ROWS: rows_reg <= cfg_data;
                    REG_COLS: cols_reg <= cfg_data;
                endcase
            end
            if (cmd.init)
            begin
                r_reg <= ROW_W'(rows_eff - 1'b1);
                c_reg <= COL_W'(cols_eff - 1'b1);
                h_reg <= HASH_SEED;
            end
            if (cmd.best_clr)
            begin
                dir_reg <= NB_CUR;
            end
            else if (take)
            begin
                dir_reg <= cmd.cmp_sel;
            end
            if (cmd.emit)
            begin
                h_reg         <= h_new;
                r_reg         <= nxt_row;
                c_reg         <= nxt_col;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_cur)
        begin
            cur_reg <= rd_data_reg;
        end
        else if (cmd.emit)
        begin
            cur_reg <= best_reg;
        end
        if (cmd.best_clr)
        begin
            best_reg <= SCORE_MIN;
        end
        else if (take)
        begin
            best_reg <= rd_data_reg;
        end
        if (cmd.emit)
        begin
            result_reg.path_row     <= r_reg;
            result_reg.path_col     <= c_reg;
            result_reg.path_score   <= cur_reg;
            result_reg.running_hash <= h_new;
            result_reg.last         <= (dir_reg == NB_CUR);
        end
    end

    // Every step of the walk moves strictly toward the origin.
    a_walk_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && sts.moved) |=>
            ((r_reg < $past(r_reg)) || (c_reg < $past(c_reg))))
        else $error("traceback step did not move toward the origin");

    // An emitted result is presented on the next cycle.
    a_emit_shows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> out_valid_reg)
        else $error("emitted result not presented");

endmodule

`default_nettype wire

// ===== src/dp_matrix_traceback_hash_unit.sv =====
// ============================================================================
// dp_matrix_traceback_hash_unit: score matrix traceback with running hash
// Loads a signed score matrix and walks the maximum-score path back to the
// origin, hashing each visited score.
// ============================================================================
// A load item (command 0) writes one 32-bit signed score at (row, col) and
// keeps the unit idle, so between runs a matrix streams in at one cell per clock; loads
// outside the MAX_ROWS by MAX_COLS array are dropped. A run item (command 1)
// starts at (rows_in_use-1, cols_in_use-1) and produces one result per path
// cell: its coordinates, its score and the running hash (seed 5381, each step
// hash*33 XOR score, modulo 2^32). From each cell the walk moves to the
// neighbor with the strictly largest score, checking diagonal, up and left in
// that order, so ties keep the earlier direction and a neighbor holding the
// most negative score is never chosen; the result with last set closes the
// walk. Sizes above the array dimensions are clamped, and a zero size makes a
// run produce nothing. The score memory has a single read port, so every path
// cell costs three neighbor reads, and the block takes no new item until the
// final result of a run sits in the output register. Scores read by a walk
// must have been loaded beforehand; the memory is not cleared at reset.
// Configuration writes are meant to happen only while the unit is idle.
// ============================================================================
`default_nettype none

module dp_matrix_traceback_hash_unit
    import dmth_pkg::*;
#(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_we,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    dmth_in_if.sink                   cmd_ch,
    dmth_out_if.source                path_ch
);

    // Command and status bundles between the sequencer and the datapath.
    dmth_cmd_t    cmd;
    dmth_sts_t    sts;
    dmth_result_t result;
    logic         out_valid;

    dmth_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd_ch.valid),
        .in_command (cmd_ch.command),
        .in_ready   (cmd_ch.ready),
        .sts        (sts),
        .cmd        (cmd)
    );

    dmth_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .load_row   (cmd_ch.row),
        .load_col   (cmd_ch.col),
        .load_score (cmd_ch.cell_score),
        .cmd        (cmd),
        .sts        (sts),
        .out_valid  (out_valid),
        .out_ready  (path_ch.ready),
        .result     (result)
    );

    // The result register drives the output channel directly; a transfer
    // there frees it for the next path cell.
    assign path_ch.valid        = out_valid;
    assign path_ch.path_row     = result.path_row;
    assign path_ch.path_col     = result.path_col;
    assign path_ch.path_score   = result.path_score;
    assign path_ch.running_hash = result.running_hash;
    assign path_ch.last         = result.last;

endmodule

`default_nettype wire
